FILE: sv/psm_pkg.sv
package psm_pkg;

    // store capacity and derived widths
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int EXT_W     = CNT_W + 1;

    // field widths
    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int PRI_W   = 8;
    localparam int SUM_W   = 24;
    localparam int AVG_W   = 32;
    localparam int FRAC_W  = 8;

    // one quotient bit per divider step
    localparam int DIV_STEPS = AVG_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRI_W-1:0]   pri;
    } rec_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RDI,
        ST_LDI,
        ST_CMP,
        ST_WRI,
        ST_SUM_RD,
        ST_SUM,
        ST_DIV_LD,
        ST_DIV,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic             mem_we;
        logic             wsel_in;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
        logic             cur_load;
        logic             cmp_step;
        logic             acc_clear;
        logic             sum_step;
        logic             wait_clear;
        logic             row_load;
        logic             row_last;
        logic             div_start;
        logic             div_step;
        logic [CNT_W-1:0] divisor;
    } dp_cmd_t;

    // 24-bit add, saturating
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

FILE: sv/psm_ctrl.sv
module psm_ctrl
    import psm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_last,
    output logic    m_valid,
    input  logic    m_ready,
    output logic    dropped,
    output dp_cmd_t cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [DSTEP_W-1:0] d_reg, d_next;

    logic             room;
    logic [CNT_W-1:0] n_load;
    logic [EXT_W-1:0] n_x, i2_x, j1_x, k1_x;

    assign room   = count_reg < CNT_W'(MAX_PROCS);
    assign n_load = room ? count_reg + CNT_W'(1) : count_reg;
    assign n_x    = {1'b0, count_reg};
    assign i2_x   = {1'b0, i_reg} + EXT_W'(2);
    assign j1_x   = {1'b0, j_reg} + EXT_W'(1);
    assign k1_x   = {1'b0, k_reg} + EXT_W'(1);

    assign dropped = ovf_reg;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            d_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            d_reg     <= d_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        cmd.divisor = count_reg;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (room) begin
                        cmd.mem_we  = 1'b1;
                        cmd.wsel_in = 1'b1;
                        cmd.waddr   = count_reg[IDX_W-1:0];
                        count_next  = n_load;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        i_next = '0;
                        state_next = (n_load > CNT_W'(1)) ? ST_RDI : ST_SUM_RD;
                    end
                end
            end
            // fetch the entry at position i
            ST_RDI: begin
                cmd.raddr  = i_reg[IDX_W-1:0];
                j_next     = i_reg + CNT_W'(1);
                state_next = ST_LDI;
            end
            ST_LDI: begin
                cmd.cur_load = 1'b1;
                cmd.raddr    = j_reg[IDX_W-1:0];
                state_next   = ST_CMP;
            end
            // one later entry per cycle, exchange on smaller priority
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
                cmd.waddr    = j_reg[IDX_W-1:0];
                if (j1_x < n_x) begin
                    cmd.raddr = j1_x[IDX_W-1:0];
                    j_next    = j1_x[CNT_W-1:0];
                end else begin
                    state_next = ST_WRI;
                end
            end
            ST_WRI: begin
                cmd.mem_we = 1'b1;
                cmd.waddr  = i_reg[IDX_W-1:0];
                i_next     = i_reg + CNT_W'(1);
                state_next = (i2_x < n_x) ? ST_RDI : ST_SUM_RD;
            end
            // totals pass
            ST_SUM_RD: begin
                cmd.acc_clear = 1'b1;
                cmd.raddr     = '0;
                k_next        = '0;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (k1_x < n_x) begin
                    cmd.raddr = k1_x[IDX_W-1:0];
                    k_next    = k1_x[CNT_W-1:0];
                end else begin
                    state_next = ST_DIV_LD;
                end
            end
            // averages
            ST_DIV_LD: begin
                cmd.div_start = 1'b1;
                d_next        = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (d_reg == DSTEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_EM_RD;
                end else begin
                    d_next = d_reg + DSTEP_W'(1);
                end
            end
            // rows in schedule order
            ST_EM_RD: begin
                cmd.wait_clear = 1'b1;
                cmd.raddr      = '0;
                k_next         = '0;
                state_next     = ST_EM_LD;
            end
            ST_EM_LD: begin
                cmd.row_load = 1'b1;
                cmd.row_last = (k1_x == n_x);
                state_next   = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (k1_x == n_x) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.raddr  = k1_x[IDX_W-1:0];
                        k_next     = k1_x[CNT_W-1:0];
                        state_next = ST_EM_LD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: sv/psm_dp.sv
module psm_dp
    import psm_pkg::*;
(
    input  logic               aclk,
    input  dp_cmd_t            cmd,
    input  logic [ID_W-1:0]    s_proc_id,
    input  logic [BURST_W-1:0] s_burst,
    input  logic [PRI_W-1:0]   s_priority_req,
    output logic [ID_W-1:0]    m_row_id,
    output logic [PRI_W-1:0]   m_row_priority,
    output logic [BURST_W-1:0] m_row_burst,
    output logic [SUM_W-1:0]   m_wait_time,
    output logic [SUM_W-1:0]   m_turnaround,
    output logic [SUM_W-1:0]   m_total_wait,
    output logic [SUM_W-1:0]   m_total_turnaround,
    output logic [AVG_W-1:0]   m_avg_wait,
    output logic [AVG_W-1:0]   m_avg_turnaround,
    output logic               m_row_last
);

    rec_t mem [MAX_PROCS];
    rec_t rd_data_reg;
    rec_t rd_data;
    rec_t cur_reg;
    rec_t wdata;
    logic swap;
    logic we;

    logic [SUM_W-1:0] wait_reg, tot_w_reg, tot_t_reg;
    logic [SUM_W-1:0] tat;

    logic [AVG_W-1:0] qw_reg, qt_reg;
    logic [CNT_W-1:0] rw_reg, rt_reg;
    logic [CNT_W:0]   shw, sht;
    logic             gew, get;

    rec_t             row_reg;
    logic [SUM_W-1:0] row_wait_reg, row_tat_reg;
    logic             row_last_reg;

    // record store, one write and one registered read per cycle
    assign swap  = cur_reg.pri > rd_data_reg.pri;
    assign we    = cmd.mem_we | (cmd.cmp_step & swap);
    assign wdata = cmd.wsel_in ? rec_t'{id: s_proc_id, burst: s_burst, pri: s_priority_req}
                               : cur_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[cmd.waddr] <= wdata;
        end
        rd_data_reg <= mem[cmd.raddr];
    end

    assign rd_data = rd_data_reg;

    // entry held for position i; smaller priority displaces it
    always_ff @(posedge aclk) begin
        if (cmd.cur_load || (cmd.cmp_step && swap)) begin
            cur_reg <= rd_data;
        end
    end

    // running wait and totals
    assign tat = sat_add(wait_reg, SUM_W'(rd_data_reg.burst));

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            wait_reg  <= '0;
            tot_w_reg <= '0;
            tot_t_reg <= '0;
        end else if (cmd.wait_clear) begin
            wait_reg <= '0;
        end else if (cmd.sum_step) begin
            wait_reg  <= tat;
            tot_w_reg <= sat_add(tot_w_reg, wait_reg);
            tot_t_reg <= sat_add(tot_t_reg, tat);
        end else if (cmd.row_load) begin
            wait_reg <= tat;
        end
    end

    // restoring dividers, one quotient bit per cycle, both totals at once
    assign shw = {rw_reg, qw_reg[AVG_W-1]};
    assign sht = {rt_reg, qt_reg[AVG_W-1]};
    assign gew = shw >= {1'b0, cmd.divisor};
    assign get = sht >= {1'b0, cmd.divisor};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qw_reg <= {tot_w_reg, FRAC_W'(0)};
            qt_reg <= {tot_t_reg, FRAC_W'(0)};
            rw_reg <= '0;
            rt_reg <= '0;
        end else if (cmd.div_step) begin
            qw_reg <= {qw_reg[AVG_W-2:0], gew};
            qt_reg <= {qt_reg[AVG_W-2:0], get};
            rw_reg <= gew ? CNT_W'(shw - {1'b0, cmd.divisor}) : shw[CNT_W-1:0];
            rt_reg <= get ? CNT_W'(sht - {1'b0, cmd.divisor}) : sht[CNT_W-1:0];
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.row_load) begin
            row_reg      <= rd_data_reg;
            row_wait_reg <= wait_reg;
            row_tat_reg  <= tat;
            row_last_reg <= cmd.row_last;
        end
    end

    assign m_row_id           = row_reg.id;
    assign m_row_priority     = row_reg.pri;
    assign m_row_burst        = row_reg.burst;
    assign m_wait_time        = row_wait_reg;
    assign m_turnaround       = row_tat_reg;
    assign m_total_wait       = row_last_reg ? tot_w_reg : '0;
    assign m_total_turnaround = row_last_reg ? tot_t_reg : '0;
    assign m_avg_wait         = row_last_reg ? qw_reg : '0;
    assign m_avg_turnaround   = row_last_reg ? qt_reg : '0;
    assign m_row_last         = row_last_reg;

endmodule

FILE: sv/priority_schedule_metrics.sv
// Loading: one record word per cycle until the word marked last.
// After last, with n records: the sort (one compare per cycle on the single read port
// of the record store), the totals pass, the dividers (one quotient bit per cycle), a
// fetch of the first row, then each row is loaded and offered until it is taken.
// Items are not accepted from the last record until the final row is taken.
// aresetn (synchronous) empties the set and clears the overflow flag; the store is not cleared.
module priority_schedule_metrics
    import psm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ID_W-1:0]    s_proc_id,
    input  logic [BURST_W-1:0] s_burst,
    input  logic [PRI_W-1:0]   s_priority_req,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ID_W-1:0]    m_row_id,
    output logic [PRI_W-1:0]   m_row_priority,
    output logic [BURST_W-1:0] m_row_burst,
    output logic [SUM_W-1:0]   m_wait_time,
    output logic [SUM_W-1:0]   m_turnaround,
    output logic [SUM_W-1:0]   m_total_wait,
    output logic [SUM_W-1:0]   m_total_turnaround,
    output logic [AVG_W-1:0]   m_avg_wait,
    output logic [AVG_W-1:0]   m_avg_turnaround,
    output logic               m_dropped,
    output logic               m_row_last
);

    dp_cmd_t cmd;

    psm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_last),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dropped (m_dropped),
        .cmd     (cmd)
    );

    psm_dp u_dp (
        .aclk               (aclk),
        .cmd                (cmd),
        .s_proc_id          (s_proc_id),
        .s_burst            (s_burst),
        .s_priority_req     (s_priority_req),
        .m_row_id           (m_row_id),
        .m_row_priority     (m_row_priority),
        .m_row_burst        (m_row_burst),
        .m_wait_time        (m_wait_time),
        .m_turnaround       (m_turnaround),
        .m_total_wait       (m_total_wait),
        .m_total_turnaround (m_total_turnaround),
        .m_avg_wait         (m_avg_wait),
        .m_avg_turnaround   (m_avg_turnaround),
        .m_row_last         (m_row_last)
    );

    // loading and row output never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output both open");

    // taking the final row reopens the input
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_row_last) |=> s_ready)
        else $error("input not reopened after final row");

    // turnaround never below wait
    a_tat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_turnaround >= m_wait_time))
        else $error("turnaround below wait time");

    // the next row starts where the previous one ended
    a_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_row_last) |=> ##1
            (m_wait_time == $past(m_turnaround, 2)))
        else $error("wait time does not follow previous turnaround");

endmodule
